>>> src/ddo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// Widths, register indexes, reset values, CORDIC constants and a saturation helper for
// the differential-drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CORDIC_STEPS_DFLT   = 16;
    localparam int POSITION_WIDTH_DFLT = 32;

    localparam int RATE_W    = 24;
    localparam int DT_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int OUT_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SEP      = 8'd1;

    localparam logic [CFG_W-1:0] RST_WHEEL_RADIUS = 16'd135;
    localparam logic [CFG_W-1:0] RST_INV_SEP      = 16'd2560;

    // datapath widths
    localparam int CRD_W   = 34;
    localparam int MUL_A_W = 42;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 68;
    localparam int ANG_W   = 33;

    localparam logic signed [CRD_W-1:0] CORDIC_X0 = 34'sd652032874;

    // round(2^32 / (2*pi)), split into a 16-bit low and a 15-bit high chunk
    localparam logic [30:0]            RAD_TO_BAM = 31'd683565276;
    localparam logic [MUL_B_W-1:0]     BAM_K_LO   = {2'b00, RAD_TO_BAM[15:0]};
    localparam logic [MUL_B_W-1:0]     BAM_K_HI   = {3'b000, RAD_TO_BAM[30:16]};

    localparam int ATAN_N     = 32;
    localparam int ATAN_IDX_W = 5;

    localparam logic [31:0] ATAN_BAM [0:ATAN_N-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [OUT_W-1:0] r;
        hi = {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            r = hi[OUT_W-1:0];
        end else if (v < lo) begin
            r = lo[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> src/diff_drive_odometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Dead-reckoning pose integrator for a differential-drive base.
// ----------------------------------------------------------------------------
// One item (two wheel rates and a time step) produces one result: the updated
// pose (x, y, heading) plus this step's forward speed and turn rate. After
// acceptance an item runs through the CORDIC iterations on the old heading,
// then twelve passes through one shared 42x18 multiplier and a heading add;
// only then can the next item be accepted. The input stalls while an item is
// in work; a finished result sits in the output register until taken, and the
// next item is accepted meanwhile. Position saturates at POSITION_WIDTH bits,
// heading wraps at a full turn.
// ----------------------------------------------------------------------------
module diff_drive_odometry
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DFLT,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DFLT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [RATE_W-1:0]    i_first_wheel_rate,
    input  logic signed [RATE_W-1:0]    i_second_wheel_rate,
    input  logic [DT_W-1:0]             i_time_step,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [OUT_W-1:0]     o_position_x,
    output logic signed [OUT_W-1:0]     o_position_y,
    output logic [OUT_W-1:0]            o_heading,
    output logic signed [OUT_W-1:0]     o_forward_speed,
    output logic signed [OUT_W-1:0]     o_turn_rate
);

    localparam int ITER_N = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;
    localparam logic [ATAN_IDX_W-1:0] ITER_LAST = ATAN_IDX_W'(ITER_N - 1);

    localparam int STEP_W = 38;
    localparam int SUM_W  = ((POSITION_WIDTH > STEP_W) ? POSITION_WIDTH : STEP_W) + 1;
    localparam int WIDE_W = (POSITION_WIDTH > OUT_W) ? POSITION_WIDTH : OUT_W + 1;

    localparam logic signed [SUM_W-1:0] POS_MAX =
        {{(SUM_W-POSITION_WIDTH+1){1'b0}}, {(POSITION_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;
    localparam logic signed [WIDE_W-1:0] OUT_MAX =
        {{(WIDE_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] OUT_MIN = ~OUT_MAX;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_MUL_SPD,
        S_MUL_RD,
        S_MUL_TRN,
        S_MUL_XL,
        S_MUL_XH,
        S_MUL_XDT,
        S_MUL_YL,
        S_MUL_YH,
        S_MUL_YDT,
        S_MUL_TDT,
        S_MUL_KL,
        S_MUL_KH,
        S_HEAD,
        S_DONE
    } t_state;

    t_state                         r_state;

    logic [CFG_W-1:0]               r_radius;
    logic [CFG_W-1:0]               r_inv_sep;

    logic signed [POSITION_WIDTH-1:0] r_px;
    logic signed [POSITION_WIDTH-1:0] r_py;
    logic [OUT_W-1:0]               r_head;

    logic signed [RATE_W:0]         r_sum;
    logic signed [RATE_W:0]         r_diff;
    logic [DT_W-1:0]                r_dt;

    logic signed [CRD_W-1:0]        r_cx;
    logic signed [CRD_W-1:0]        r_cy;
    logic signed [CRD_W-1:0]        r_cz;
    logic                           r_flip;
    logic [ATAN_IDX_W-1:0]          r_iter;

    logic signed [ACC_W-1:0]        r_acc;
    logic signed [OUT_W-1:0]        r_speed;
    logic signed [OUT_W-1:0]        r_turn;
    logic signed [ANG_W-1:0]        r_ang;

    logic                           r_out_valid;
    logic signed [OUT_W-1:0]        r_out_x;
    logic signed [OUT_W-1:0]        r_out_y;
    logic [OUT_W-1:0]               r_out_head;
    logic signed [OUT_W-1:0]        r_out_speed;
    logic signed [OUT_W-1:0]        r_out_turn;

    logic                           in_acc;
    logic                           out_free;

    // CORDIC iteration
    logic signed [CRD_W-1:0]        dx;
    logic signed [CRD_W-1:0]        dy;
    logic signed [CRD_W-1:0]        atan_z;
    logic signed [CRD_W-1:0]        n_cx;
    logic signed [CRD_W-1:0]        n_cy;
    logic signed [CRD_W-1:0]        n_cz;

    // heading fold into [-pi/2, pi/2)
    logic                           fold_flip;
    logic [OUT_W-1:0]               fold_ang;

    // shared multiplier
    logic signed [CRD_W-1:0]        cos_v;
    logic signed [CRD_W-1:0]        sin_v;
    logic signed [CRD_W-1:0]        trig_v;
    logic signed [MUL_A_W-1:0]      mul_a;
    logic signed [MUL_B_W-1:0]      mul_b;
    logic signed [MUL_P_W-1:0]      mul_a_x;
    logic signed [MUL_P_W-1:0]      mul_b_x;
    logic signed [MUL_P_W-1:0]      mul_p;
    logic signed [ACC_W-1:0]        acc_hi;

    logic signed [ACC_W-1:0]        acc_sh9;
    logic signed [ACC_W-1:0]        acc_sh16;
    logic signed [ACC_W-1:0]        acc_sh30;

    // position accumulate
    logic signed [POSITION_WIDTH-1:0] pos_cur;
    logic signed [SUM_W-1:0]        pos_sum;
    logic signed [POSITION_WIDTH-1:0] n_pos;

    logic signed [WIDE_W-1:0]       px_wide;
    logic signed [WIDE_W-1:0]       py_wide;
    logic signed [OUT_W-1:0]        px_sat;
    logic signed [OUT_W-1:0]        py_sat;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    assign fold_flip = r_head[31] ^ r_head[30];
    assign fold_ang  = fold_flip ? (r_head + 32'h8000_0000) : r_head;

    assign dx     = r_cy >>> r_iter;
    assign dy     = r_cx >>> r_iter;
    assign atan_z = $signed({2'b00, ATAN_BAM[r_iter]});

    always_comb begin
        if (!r_cz[CRD_W-1]) begin
            n_cx = r_cx - dx;
            n_cy = r_cy + dy;
            n_cz = r_cz - atan_z;
        end else begin
            n_cx = r_cx + dx;
            n_cy = r_cy - dy;
            n_cz = r_cz + atan_z;
        end
    end

    assign cos_v  = r_flip ? -r_cx : r_cx;
    assign sin_v  = r_flip ? -r_cy : r_cy;
    assign trig_v = ((r_state == S_MUL_XL) || (r_state == S_MUL_XH)) ? cos_v : sin_v;

    assign acc_sh9  = r_acc >>> 9;
    assign acc_sh16 = r_acc >>> 16;
    assign acc_sh30 = r_acc >>> 30;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MUL_SPD: begin
                mul_a = MUL_A_W'(r_sum);
                mul_b = $signed({2'b00, r_radius});
            end
            S_MUL_RD: begin
                mul_a = MUL_A_W'(r_diff);
                mul_b = $signed({2'b00, r_radius});
            end
            S_MUL_TRN: begin
                mul_a = r_acc[MUL_A_W-1:0];
                mul_b = $signed({2'b00, r_inv_sep});
            end
            S_MUL_XL, S_MUL_YL: begin
                mul_a = MUL_A_W'(r_speed);
                mul_b = $signed({2'b00, trig_v[15:0]});
            end
            S_MUL_XH, S_MUL_YH: begin
                mul_a = MUL_A_W'(r_speed);
                mul_b = trig_v[CRD_W-1:16];
            end
            S_MUL_XDT, S_MUL_YDT: begin
                mul_a = acc_sh30[MUL_A_W-1:0];
                mul_b = $signed({2'b00, r_dt});
            end
            S_MUL_TDT: begin
                mul_a = MUL_A_W'(r_turn);
                mul_b = $signed({2'b00, r_dt});
            end
            S_MUL_KL: begin
                mul_a = MUL_A_W'($signed(acc_sh16[ANG_W-1:0]));
                mul_b = $signed(BAM_K_LO);
            end
            S_MUL_KH: begin
                mul_a = MUL_A_W'(r_ang);
                mul_b = $signed(BAM_K_HI);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_a_x = MUL_P_W'(mul_a);
    assign mul_b_x = MUL_P_W'(mul_b);
    assign mul_p   = mul_a_x * mul_b_x;
    assign acc_hi  = r_acc + (ACC_W'(mul_p) <<< 16);

    assign pos_cur = (r_state == S_MUL_YL) ? r_px : r_py;
    assign pos_sum = SUM_W'(pos_cur) + SUM_W'($signed(acc_sh16[STEP_W-1:0]));

    always_comb begin
        if (pos_sum > POS_MAX) begin
            n_pos = POS_MAX[POSITION_WIDTH-1:0];
        end else if (pos_sum < POS_MIN) begin
            n_pos = POS_MIN[POSITION_WIDTH-1:0];
        end else begin
            n_pos = pos_sum[POSITION_WIDTH-1:0];
        end
    end

    assign px_wide = WIDE_W'(r_px);
    assign py_wide = WIDE_W'(r_py);

    always_comb begin
        if (px_wide > OUT_MAX) begin
            px_sat = OUT_MAX[OUT_W-1:0];
        end else if (px_wide < OUT_MIN) begin
            px_sat = OUT_MIN[OUT_W-1:0];
        end else begin
            px_sat = px_wide[OUT_W-1:0];
        end
        if (py_wide > OUT_MAX) begin
            py_sat = OUT_MAX[OUT_W-1:0];
        end else if (py_wide < OUT_MIN) begin
            py_sat = OUT_MIN[OUT_W-1:0];
        end else begin
            py_sat = py_wide[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radius    <= RST_WHEEL_RADIUS;
            r_inv_sep   <= RST_INV_SEP;
            r_px        <= '0;
            r_py        <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_WHEEL_RADIUS: r_radius  <= i_cfg_data;
                    REG_INV_SEP:      r_inv_sep <= i_cfg_data;
                    default:          ;
                endcase
            end

            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sum  <= (RATE_W+1)'(i_first_wheel_rate)
                                + (RATE_W+1)'(i_second_wheel_rate);
                        r_diff <= (RATE_W+1)'(i_first_wheel_rate)
                                - (RATE_W+1)'(i_second_wheel_rate);
                        r_dt   <= i_time_step;
                        r_cx   <= CORDIC_X0;
                        r_cy   <= '0;
                        r_cz   <= CRD_W'($signed(fold_ang));
                        r_flip <= fold_flip;
                        r_iter <= '0;
                        r_state <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    r_cx   <= n_cx;
                    r_cy   <= n_cy;
                    r_cz   <= n_cz;
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ITER_LAST) begin
                        r_state <= S_MUL_SPD;
                    end
                end
                S_MUL_SPD: begin
                    r_acc   <= ACC_W'(mul_p);
                    r_state <= S_MUL_RD;
                end
                S_MUL_RD: begin
                    r_speed <= sat_out(acc_sh9);
                    r_acc   <= ACC_W'(mul_p);
                    r_state <= S_MUL_TRN;
                end
                S_MUL_TRN: begin
                    r_acc   <= ACC_W'(mul_p);
                    r_state <= S_MUL_XL;
                end
                S_MUL_XL: begin
                    r_turn  <= sat_out(acc_sh16);
                    r_acc   <= ACC_W'(mul_p);
                    r_state <= S_MUL_XH;
                end
                S_MUL_XH: begin
                    r_acc   <= acc_hi;
                    r_state <= S_MUL_XDT;
                end
                S_MUL_XDT: begin
                    r_acc   <= ACC_W'(mul_p);
                    r_state <= S_MUL_YL;
                end
                S_MUL_YL: begin
                    r_px    <= n_pos;
                    r_acc   <= ACC_W'(mul_p);
                    r_state <= S_MUL_YH;
                end
                S_MUL_YH: begin
                    r_acc   <= acc_hi;
                    r_state <= S_MUL_YDT;
                end
                S_MUL_YDT: begin
                    r_acc   <= ACC_W'(mul_p);
                    r_state <= S_MUL_TDT;
                end
                S_MUL_TDT: begin
                    r_py    <= n_pos;
                    r_acc   <= ACC_W'(mul_p);
                    r_state <= S_MUL_KL;
                end
                S_MUL_KL: begin
                    r_ang   <= acc_sh16[ANG_W-1:0];
                    r_acc   <= ACC_W'(mul_p);
                    r_state <= S_MUL_KH;
                end
                S_MUL_KH: begin
                    r_acc   <= acc_hi;
                    r_state <= S_HEAD;
                end
                S_HEAD: begin
                    // low 32 bits of floor(a*K / 2^16), added mod a full turn
                    r_head  <= r_head + r_acc[47:16];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_x     <= px_sat;
                        r_out_y     <= py_sat;
                        r_out_head  <= r_head;
                        r_out_speed <= r_speed;
                        r_out_turn  <= r_turn;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_position_x    = r_out_x;
    assign o_position_y    = r_out_y;
    assign o_heading       = r_out_head;
    assign o_forward_speed = r_out_speed;
    assign o_turn_rate     = r_out_turn;

endmodule

>>> tb/diff_drive_odometry_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_tb
// Self-checking bench for the differential-drive odometry block.
// ----------------------------------------------------------------------------
// A queue-fed driver sends wheel-rate items and a clocked monitor takes
// results, both with random gaps. Each accepted item runs through a local
// fixed-point pose integrator (speed, turn, CORDIC on the old heading,
// saturating position, wrapping heading). Every result is checked field by
// field against the oldest prediction. Registers are rewritten between phases
// while the block is idle: reset values, zero gains, full-scale gains,
// out-of-range indexes and random settings.
// ----------------------------------------------------------------------------
module diff_drive_odometry_tb;
    import ddo_pkg::*;

    localparam int STEPS   = CORDIC_STEPS_DFLT;
    localparam int POS_W   = POSITION_WIDTH_DFLT;
    localparam int LATENCY = STEPS + 15;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 8'hFF;

    localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};
    localparam logic [DT_W-1:0]          DT_MAX   = '1;

    typedef struct packed {
        logic [RATE_W-1:0] w1;
        logic [RATE_W-1:0] w2;
        logic [DT_W-1:0]   dt;
    } t_wheel_item;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] hdg;
        logic [OUT_W-1:0] spd;
        logic [OUT_W-1:0] trn;
    } t_pose_result;

    logic                     i_clk               = 1'b0;
    logic                     i_rst_n             = 1'b0;
    logic                     i_cfg_valid         = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index         = '0;
    logic [CFG_W-1:0]         i_cfg_data          = '0;
    logic                     i_in_valid          = 1'b0;
    logic signed [RATE_W-1:0] i_first_wheel_rate  = '0;
    logic signed [RATE_W-1:0] i_second_wheel_rate = '0;
    logic [DT_W-1:0]          i_time_step         = '0;
    logic                     i_out_stall         = 1'b0;

    logic                     o_cfg_ready;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [OUT_W-1:0]  o_position_x;
    logic signed [OUT_W-1:0]  o_position_y;
    logic [OUT_W-1:0]         o_heading;
    logic signed [OUT_W-1:0]  o_forward_speed;
    logic signed [OUT_W-1:0]  o_turn_rate;

    // local copy of registers and pose
    logic [CFG_W-1:0] radius_q412 = RST_WHEEL_RADIUS;
    logic [CFG_W-1:0] inv_sep_q88 = RST_INV_SEP;
    longint           pose_x_acc  = 0;
    longint           pose_y_acc  = 0;
    logic [31:0]      pose_bam    = '0;

    t_wheel_item  wheel_item_q[$];
    t_pose_result pose_expected_q[$];

    int   mismatch_count = 0;
    int   in_gap_max     = 13;
    int   out_gap_max    = 13;
    int   in_wait        = 0;
    int   out_wait       = 0;
    logic in_fire        = 1'b0;
    logic out_fire       = 1'b0;

    diff_drive_odometry #(
        .CORDIC_STEPS   (STEPS),
        .POSITION_WIDTH (POS_W)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_first_wheel_rate  (i_first_wheel_rate),
        .i_second_wheel_rate (i_second_wheel_rate),
        .i_time_step         (i_time_step),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_position_x        (o_position_x),
        .o_position_y        (o_position_y),
        .o_heading           (o_heading),
        .o_forward_speed     (o_forward_speed),
        .o_turn_rate         (o_turn_rate)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp_signed(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic void heading_cos_sin(input logic [31:0] bam,
                                            output longint c, output longint s);
        logic        flip;
        logic [31:0] folded;
        longint      z;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        int          n;
        int          i;
        flip   = bam[31] ^ bam[30];
        folded = flip ? bam + 32'h8000_0000 : bam;
        z      = longint'($signed(folded));
        x      = longint'(CORDIC_X0);
        y      = 0;
        n      = (STEPS > 32) ? 32 : STEPS;
        for (i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_BAM[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_BAM[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic t_pose_result integrate_pose(input t_wheel_item it);
        longint       w1;
        longint       w2;
        longint       dt;
        longint       rad;
        longint       isep;
        longint       spd;
        longint       trn;
        longint       c;
        longint       s;
        longint       ang;
        t_pose_result res;
        w1   = longint'($signed(it.w1));
        w2   = longint'($signed(it.w2));
        dt   = longint'(it.dt);
        rad  = longint'(radius_q412);
        isep = longint'(inv_sep_q88);
        spd  = clamp_signed(((w1 + w2) * rad) >>> 9, 32);
        trn  = clamp_signed(((w1 - w2) * rad * isep) >>> 16, 32);
        heading_cos_sin(pose_bam, c, s);
        pose_x_acc = clamp_signed(pose_x_acc + ((((spd * c) >>> 30) * dt) >>> 16), POS_W);
        pose_y_acc = clamp_signed(pose_y_acc + ((((spd * s) >>> 30) * dt) >>> 16), POS_W);
        ang      = (trn * dt) >>> 16;
        ang      = (ang * longint'(RAD_TO_BAM)) >>> 16;
        pose_bam = pose_bam + ang[31:0];
        res.x    = 32'(clamp_signed(pose_x_acc, 32));
        res.y    = 32'(clamp_signed(pose_y_acc, 32));
        res.hdg  = pose_bam;
        res.spd  = 32'(spd);
        res.trn  = 32'(trn);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    // sender: one item at a time, random gap after each
    always @(negedge i_clk) begin : feeder
        t_wheel_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (in_wait > 0) begin
                in_wait--;
                i_in_valid <= 1'b0;
            end else if (wheel_item_q.size() > 0) begin
                nxt = wheel_item_q.pop_front();
                i_first_wheel_rate  <= nxt.w1;
                i_second_wheel_rate <= nxt.w2;
                i_time_step         <= nxt.dt;
                i_in_valid          <= 1'b1;
                in_wait = $urandom_range(0, in_gap_max);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin : sink
        if (out_fire) begin
            out_wait = $urandom_range(0, out_gap_max);
        end
        if (out_wait > 0) begin
            out_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_pose_result want;
        t_wheel_item  seen;
        in_fire  <= i_rst_n && i_in_valid && !o_in_stall;
        out_fire <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pose_expected_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, x=%h", o_position_x));
            end else begin
                want = pose_expected_q.pop_front();
                check_field("position_x", o_position_x, want.x);
                check_field("position_y", o_position_y, want.y);
                check_field("heading", o_heading, want.hdg);
                check_field("forward_speed", o_forward_speed, want.spd);
                check_field("turn_rate", o_turn_rate, want.trn);
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            seen.w1 = i_first_wheel_rate;
            seen.w2 = i_second_wheel_rate;
            seen.dt = i_time_step;
            pose_expected_q.push_back(integrate_pose(seen));
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_WHEEL_RADIUS) begin
            radius_q412 = val;
        end else if (idx == REG_INV_SEP) begin
            inv_sep_q88 = val;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_item(input logic [RATE_W-1:0] a, input logic [RATE_W-1:0] b,
                              input logic [DT_W-1:0] dt);
        t_wheel_item it;
        it.w1 = a;
        it.w2 = b;
        it.dt = dt;
        wheel_item_q.push_back(it);
    endtask

    // mostly plausible robot motion, some full-range noise
    task automatic queue_random(input int n);
        int          k;
        int          pick;
        int          a;
        int          b;
        logic [15:0] dt;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            a    = int'($urandom_range(0, 163840)) - 81920;
            b    = int'($urandom_range(0, 163840)) - 81920;
            dt   = 16'($urandom_range(0, 1311));
            unique case (pick)
                0: begin
                    a  = $urandom;
                    b  = $urandom;
                    dt = 16'($urandom);
                end
                7: begin
                    dt = $urandom_range(0, 1) ? DT_MAX : '0;
                end
                8: begin
                    b = a;
                end
                9: begin
                    b  = -a;
                    dt = 16'($urandom_range(0, 13107));
                end
                default: begin
                end
            endcase
            queue_item(a[RATE_W-1:0], b[RATE_W-1:0], dt);
        end
    endtask

    task automatic wait_idle();
        while (wheel_item_q.size() > 0 || i_in_valid || pose_expected_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset gains
        queue_item('0, '0, '0);
        queue_item('0, '0, DT_MAX);
        queue_item(RATE_MAX, RATE_MAX, DT_MAX);
        queue_item(RATE_MIN, RATE_MIN, DT_MAX);
        queue_item(RATE_MAX, RATE_MIN, DT_MAX);
        queue_item(RATE_MIN, RATE_MAX, DT_MAX);
        queue_item(RATE_MAX, RATE_MIN, '0);
        queue_item(24'sd4096, 24'sd4096, 16'd1);
        queue_item(24'sd81920, -24'sd81920, 16'd6554);
        queue_item(-24'sd1, -24'sd1, DT_MAX);
        queue_item(24'sd1, -24'sd1, 16'd1);
        wait_idle();

        // zero gains, stray index
        write_register(REG_WHEEL_RADIUS, '0);
        write_register(REG_INV_SEP, '0);
        write_register(REG_UNUSED, 16'hA5A5);
        queue_item(RATE_MAX, RATE_MIN, DT_MAX);
        queue_item(24'sd81920, 24'sd40960, 16'd6554);
        wait_idle();
        write_register(REG_WHEEL_RADIUS, 16'd4096);
        queue_item(RATE_MAX, RATE_MIN, DT_MAX);
        queue_item(24'sd81920, 24'sd40960, DT_MAX);
        wait_idle();

        // full-scale gains: turn and position saturate
        write_register(REG_WHEEL_RADIUS, '1);
        write_register(REG_INV_SEP, '1);
        queue_item(RATE_MAX, RATE_MAX, DT_MAX);
        queue_item(RATE_MAX, RATE_MAX, DT_MAX);
        queue_item(RATE_MIN, RATE_MIN, DT_MAX);
        queue_item(RATE_MIN, RATE_MIN, DT_MAX);
        queue_item(RATE_MIN, RATE_MIN, DT_MAX);
        queue_item(RATE_MAX, RATE_MIN, DT_MAX);
        queue_item(RATE_MIN, RATE_MAX, 16'd1);
        wait_idle();

        // random phases
        write_register(REG_TOP, 16'hFFFF);
        write_register(REG_WHEEL_RADIUS, 16'd4096);
        write_register(REG_INV_SEP, 16'd256);
        in_gap_max  = 0;
        out_gap_max = 0;
        queue_random(200);
        wait_idle();

        write_register(REG_WHEEL_RADIUS, CFG_W'($urandom_range(0, 65535)));
        write_register(REG_INV_SEP, CFG_W'($urandom_range(0, 65535)));
        in_gap_max  = 13;
        out_gap_max = 13;
        queue_random(250);
        wait_idle();

        write_register(REG_WHEEL_RADIUS, RST_WHEEL_RADIUS);
        write_register(REG_INV_SEP, RST_INV_SEP);
        out_gap_max = 0;
        queue_random(250);
        wait_idle();

        write_register(REG_WHEEL_RADIUS, CFG_W'($urandom_range(50, 400)));
        write_register(REG_INV_SEP, CFG_W'($urandom_range(128, 4096)));
        in_gap_max  = 0;
        out_gap_max = 13;
        queue_random(250);
        wait_idle();

        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
